// File: rtl/core/dhd_pkg.sv
// Shared types and constants for the detection head decode filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package dhd_pkg;

  localparam int VALUE_W     = 16;
  localparam int DIM_W       = 14;
  localparam int CORNER_W    = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

  // Kept detection as handed from the front to the back.
  typedef struct packed {
    logic [15:0]        pred_index;
    logic [6:0]         class_index;
    logic [15:0]        confidence;
    logic [VALUE_W-1:0] cx;
    logic [VALUE_W-1:0] cy;
    logic [VALUE_W-1:0] w;
    logic [VALUE_W-1:0] h;
    logic               frame_done;
  } cand_t;

endpackage

`default_nettype wire

// File: rtl/core/dhd_front.sv
// Front end: accepts prediction elements, holds box fields and objectness,
// runs the class argmax and pushes kept detections. Depends on dhd_pkg.
`default_nettype none

module dhd_front #(
  parameter int MAX_CLASSES     = 128,
  parameter int MAX_PREDICTIONS = 65536
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [15:0]               s_tdata,
  input  wire logic                      s_tlast,
  input  wire logic [15:0]               conf_threshold,
  input  wire logic [7:0]                class_count,
  input  wire logic [dhd_pkg::QLVL_W-1:0] q_level,
  output logic                           push,
  output dhd_pkg::cand_t                 push_data
);
  import dhd_pkg::*;

  localparam int POS_W  = $clog2(MAX_CLASSES + 5);
  localparam int PRED_W = (MAX_PREDICTIONS > 1) ? $clog2(MAX_PREDICTIONS) : 1;

  logic [POS_W-1:0]   pos;
  logic [PRED_W-1:0]  pred;
  logic [VALUE_W-1:0] box [4];
  logic [VALUE_W-1:0] obj;
  logic [VALUE_W-1:0] best;
  logic [POS_W-1:0]   top_class;

  logic               s1_valid;
  logic               s1_is_obj;
  logic               s1_is_cls;
  logic               s1_last;
  logic               s1_eof;
  logic [VALUE_W-1:0] s1_prod;
  logic [POS_W-1:0]   s1_cls;
  logic [PRED_W-1:0]  s1_pred;
  logic [VALUE_W-1:0] s1_box [4];
  logic [VALUE_W-1:0] s1_obj;

  logic               acc;
  logic [POS_W-1:0]   last_pos;
  logic               end_pred;
  logic [31:0]        prod_full;
  logic               s1_better;
  logic [VALUE_W-1:0] fin_best;
  logic [POS_W-1:0]   fin_cls;
  logic               s1_pending;

  always_comb begin
    if (class_count == 8'd0) begin
      last_pos = POS_W'(5);
    end else if (32'(class_count) > MAX_CLASSES) begin
      last_pos = POS_W'(MAX_CLASSES + 4);
    end else begin
      last_pos = POS_W'(class_count) + POS_W'(4);
    end
  end

  // Leave room for the detection still in the argmax stage and the one
  // this element could end.
  assign s1_pending = s1_valid & s1_last;
  assign s_tready   = ({1'b0, q_level} + (QLVL_W + 1)'(s1_pending)) < (QLVL_W + 1)'(QUEUE_DEPTH);
  assign acc        = s_tvalid & s_tready;
  assign end_pred   = pos >= last_pos;
  assign prod_full  = 32'(obj) * 32'(s_tdata);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      pred   <= '0;
      obj    <= '0;
      box[0] <= '0;
      box[1] <= '0;
      box[2] <= '0;
      box[3] <= '0;
    end else if (acc) begin
      if (pos < POS_W'(4)) begin
        box[pos[1:0]] <= s_tdata;
      end
      if (pos == POS_W'(4)) begin
        obj <= s_tdata;
      end
      if (end_pred) begin
        pos <= '0;
        if (s_tlast || pred == PRED_W'(MAX_PREDICTIONS - 1)) begin
          pred <= '0;
        end else begin
          pred <= pred + PRED_W'(1);
        end
      end else if (s_tlast) begin
        pos  <= '0;
        pred <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_is_obj <= pos == POS_W'(4);
      s1_is_cls <= pos > POS_W'(4);
      s1_last   <= end_pred;
      s1_eof    <= s_tlast;
      s1_prod   <= prod_full[31:16];
      s1_cls    <= pos - POS_W'(5);
      s1_pred   <= pred;
      s1_box    <= box;
      s1_obj    <= obj;
    end
  end

  // Strictly greater wins, so the lower class keeps a tie.
  assign s1_better = s1_is_cls && (s1_prod > best);
  assign fin_best  = s1_better ? s1_prod : best;
  assign fin_cls   = s1_better ? s1_cls : top_class;

  always_ff @(posedge clk) begin
    if (rst) begin
      best      <= '0;
      top_class <= '0;
    end else if (s1_valid) begin
      if (s1_is_obj) begin
        best      <= '0;
        top_class <= '0;
      end else begin
        best      <= fin_best;
        top_class <= fin_cls;
      end
    end
  end

  assign push = s1_valid && s1_last && (s1_obj >= conf_threshold) &&
                (fin_best >= conf_threshold);

  always_comb begin
    push_data.pred_index  = 16'(s1_pred);
    push_data.class_index = 7'(fin_cls);
    push_data.confidence  = fin_best;
    push_data.cx          = s1_box[0];
    push_data.cy          = s1_box[1];
    push_data.w           = s1_box[2];
    push_data.h           = s1_box[3];
    push_data.frame_done  = s1_eof;
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_CLASSES + 4))
    else $error("element position beyond last class");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    acc && s_tlast |=> pos == '0 && pred == '0)
    else $error("frame end did not restart position and index");

endmodule

`default_nettype wire

// File: rtl/core/dhd_queue.sv
// Short detection queue between front and back.
// Depends on dhd_pkg for the entry type and depth.
`default_nettype none

module dhd_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire dhd_pkg::cand_t            push_data,
  input  wire logic                      pop,
  output dhd_pkg::cand_t                 pop_data,
  output logic                           valid,
  output logic [dhd_pkg::QLVL_W-1:0]     level
);
  import dhd_pkg::*;

  cand_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign valid    = level != '0;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + QLVL_W'(1);
      end else if (pop && !push) begin
        level <= level - QLVL_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (level < QLVL_W'(QUEUE_DEPTH)) || pop)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> level != '0)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: rtl/core/dhd_back.sv
// Back end: scales box corners by image size, clamps them and drives the
// result stream from an output register. Depends on dhd_pkg.
`default_nettype none

module dhd_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire dhd_pkg::cand_t             q_data,
  output logic                            pop,
  input  wire logic [dhd_pkg::DIM_W-1:0]  image_width,
  input  wire logic [dhd_pkg::DIM_W-1:0]  image_height,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [111:0]                    m_tdata,
  output logic                            m_tlast
);
  import dhd_pkg::*;

  localparam int PROD_W = VALUE_W + DIM_W;

  function automatic logic [CORNER_W-1:0] corner_lo(input logic [PROD_W-1:0] cp,
                                                    input logic [PROD_W-1:0] sp);
    logic [PROD_W:0] centre2;
    logic [PROD_W:0] diff;
    begin
      centre2 = {cp, 1'b0};
      diff    = centre2 - (PROD_W + 1)'(sp);
      if (centre2 > (PROD_W + 1)'(sp)) begin
        corner_lo = CORNER_W'(diff >> 13);
      end else begin
        corner_lo = '0;
      end
    end
  endfunction

  function automatic logic [CORNER_W-1:0] corner_hi(input logic [PROD_W-1:0] cp,
                                                    input logic [PROD_W-1:0] sp,
                                                    input logic [DIM_W-1:0]  dim);
    logic [PROD_W+1:0]     total;
    logic [PROD_W-12:0]    hi;
    logic [CORNER_W-1:0]   limit;
    begin
      total = (PROD_W + 2)'({cp, 1'b0}) + (PROD_W + 2)'(sp);
      hi    = total[PROD_W+1:13];
      limit = {dim, 4'b0000};
      if (hi > (PROD_W - 11)'(limit)) begin
        corner_hi = limit;
      end else begin
        corner_hi = CORNER_W'(hi);
      end
    end
  endfunction

  logic              b1_valid;
  cand_t             b1;
  logic [PROD_W-1:0] pxc;
  logic [PROD_W-1:0] pxs;
  logic [PROD_W-1:0] pyc;
  logic [PROD_W-1:0] pys;
  logic              out_adv;
  logic              b1_take;

  assign out_adv = !m_tvalid || m_tready;
  assign b1_take = b1_valid && out_adv;
  assign pop     = q_valid && (!b1_valid || out_adv);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        b1_valid <= 1'b1;
      end else if (b1_take) begin
        b1_valid <= 1'b0;
      end
      if (out_adv) begin
        m_tvalid <= b1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1  <= q_data;
      pxc <= PROD_W'(q_data.cx) * PROD_W'(image_width);
      pxs <= PROD_W'(q_data.w) * PROD_W'(image_width);
      pyc <= PROD_W'(q_data.cy) * PROD_W'(image_height);
      pys <= PROD_W'(q_data.h) * PROD_W'(image_height);
    end
  end

  always_ff @(posedge clk) begin
    if (b1_take) begin
      m_tdata <= {1'b0,
                  corner_hi(pyc, pys, image_height),
                  corner_hi(pxc, pxs, image_width),
                  corner_lo(pyc, pys),
                  corner_lo(pxc, pxs),
                  b1.confidence,
                  b1.class_index,
                  b1.pred_index};
      m_tlast <= b1.frame_done;
    end
  end

  a_pop_fills: assert property (@(posedge clk) disable iff (rst)
    pop |=> b1_valid)
    else $error("popped detection lost before product stage");

endmodule

`default_nettype wire

// File: rtl/core/detection_head_decode_filter.sv
// Top level of the detection head decode filter: APB register file and the
// front, queue and back sub-blocks. Depends on dhd_pkg, dhd_front, dhd_queue, dhd_back.
//
// The block takes one prediction element per cycle (cx, cy, w, h, objectness,
// then class_count class scores, all unsigned Q0.16) and emits at most one
// detection per prediction, on its last element, when objectness and the best
// objectness-times-score product both reach conf_threshold. Input rate is one
// element per clock; s_tready drops only when the four-entry detection queue
// has no room for what the front may still push, which happens only when the
// result side has been stalled for a while. From the last element of a
// prediction, the result reaches m_tdata through the front's multiply stage,
// whose argmax decision pushes the queue, the queue entry, the back's corner
// multiply stage and the output register. Since every prediction has at least
// six elements, results never limit the input rate with an idle result side.
// Corners are in pixels with 4 fraction bits, left and top clamped at 0,
// right and bottom clamped to the image size times 16. end_of_frame on s_tlast
// restarts the prediction index; frame_done on m_tlast marks a detection from
// that element. Write configuration only while the block is idle.
`default_nettype none

module detection_head_decode_filter #(
  parameter int MAX_CLASSES     = 128,
  parameter int MAX_PREDICTIONS = 65536
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Element stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,   // [15:0] value
  input  wire logic         s_tlast,   // end_of_frame
  // Detection stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata,   // [15:0] pred_index, [22:16] class_index,
                                       // [38:23] confidence, [56:39] left_x,
                                       // [74:57] top_y, [92:75] right_x,
                                       // [110:93] bottom_y, [111] zero
  output logic              m_tlast,   // frame_done
  // Register port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import dhd_pkg::*;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_CLASSES   = 2'd1;
  localparam logic [1:0] REG_WIDTH     = 2'd2;
  localparam logic [1:0] REG_HEIGHT    = 2'd3;

  logic [15:0]       conf_threshold;
  logic [7:0]        class_count;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic              wr_en;

  logic              push;
  cand_t             push_data;
  logic              pop;
  cand_t             pop_data;
  logic              q_valid;
  logic [QLVL_W-1:0] q_level;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes keep the low bits of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      conf_threshold <= 16'd16384;
      class_count    <= 8'd80;
      image_width    <= 14'd640;
      image_height   <= 14'd640;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_THRESHOLD: conf_threshold <= pwdata[15:0];
        REG_CLASSES:   class_count    <= pwdata[7:0];
        REG_WIDTH:     image_width    <= pwdata[DIM_W-1:0];
        REG_HEIGHT:    image_height   <= pwdata[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD: prdata = {16'd0, conf_threshold};
      REG_CLASSES:   prdata = {24'd0, class_count};
      REG_WIDTH:     prdata = {{(32 - DIM_W){1'b0}}, image_width};
      REG_HEIGHT:    prdata = {{(32 - DIM_W){1'b0}}, image_height};
      default:       prdata = '0;
    endcase
  end

  // Front: element bookkeeping, argmax and threshold decision.
  dhd_front #(
    .MAX_CLASSES     (MAX_CLASSES),
    .MAX_PREDICTIONS (MAX_PREDICTIONS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .conf_threshold (conf_threshold),
    .class_count    (class_count),
    .q_level        (q_level),
    .push           (push),
    .push_data      (push_data)
  );

  // Queue: absorb kept detections while the result side stalls.
  dhd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .valid     (q_valid),
    .level     (q_level)
  );

  // Back: scale and clamp corners, drive the result stream.
  dhd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (pop_data),
    .pop          (pop),
    .image_width  (image_width),
    .image_height (image_height),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

`default_nettype wire

// File: verif/dhd_tb_pkg.sv
// Register map and limits shared by the detection decode testbench files.
// No dependencies; imported by the checker and the testbench top.
package dhd_tb_pkg;

  // Byte addresses of the configuration registers on the APB port.
  typedef enum logic [3:0] {
    REG_CONF_THRESHOLD = 4'h0,
    REG_CLASS_COUNT    = 4'h4,
    REG_IMAGE_WIDTH    = 4'h8,
    REG_IMAGE_HEIGHT   = 4'hC
  } reg_addr_e;

  localparam int unsigned MAX_CLASS_COUNT = 128;

endpackage

// File: verif/dhd_checker.sv
// Scoreboard for the detection head decode filter: snoops the element, detection
// and APB channels, predicts every detection and compares it field by field.
// Depends on dhd_pkg and dhd_tb_pkg.
module dhd_checker
  import dhd_pkg::*;
  import dhd_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [15:0]       s_tdata,   // [15:0] value
  input  logic              s_tlast,   // end_of_frame
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [111:0]      m_tdata,   // pred_index, class_index, confidence, corners
  input  logic              m_tlast,   // frame_done
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       mismatch_count,
  output int unsigned       pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                frame_done;
    logic [CORNER_W-1:0] bottom_y;
    logic [CORNER_W-1:0] right_x;
    logic [CORNER_W-1:0] top_y;
    logic [CORNER_W-1:0] left_x;
    logic [15:0]         confidence;
    logic [6:0]          class_index;
    logic [15:0]         pred_index;
  } detection_t;

  string field_name [8] = '{"pred_index", "class_index", "confidence", "left_x",
                            "top_y", "right_x", "bottom_y", "frame_done"};

  detection_t pending_detections [$];

  // Configuration copy
  logic [15:0]      thr;
  logic [7:0]       cls_cnt;
  logic [DIM_W-1:0] img_w;
  logic [DIM_W-1:0] img_h;

  // Decoder state
  logic [7:0]         elem_pos;
  logic [15:0]        pred_count;
  logic [VALUE_W-1:0] box [4];
  logic [VALUE_W-1:0] obj_held;
  logic [15:0]        best_prod;
  logic [6:0]         top_class;

  int unsigned errors;
  int unsigned seen;

  // Corner pair along one axis, exact in units of 2^-17 pixel, then cut to 4 fraction bits.
  function automatic void axis_span(input logic [15:0] c, input logic [15:0] s,
                                    input logic [DIM_W-1:0] dim,
                                    output logic [CORNER_W-1:0] lo,
                                    output logic [CORNER_W-1:0] hi);
    logic [63:0] twice_c;
    logic [63:0] extent;
    logic [63:0] limit;
    logic [63:0] far;
    twice_c = 64'(c) * 64'(dim) * 64'd2;
    extent  = 64'(s) * 64'(dim);
    limit   = 64'(dim) << 4;
    lo  = (twice_c > extent) ? CORNER_W'((twice_c - extent) >> 13) : '0;
    far = (twice_c + extent) >> 13;
    hi  = CORNER_W'((far > limit) ? limit : far);
  endfunction

  task automatic decode_element(input logic [15:0] v, input logic eof);
    int unsigned classes;
    logic [7:0]  final_pos;
    logic [15:0] prod;
    detection_t  d;
    classes = (cls_cnt == 0) ? 1 : (cls_cnt > MAX_CLASS_COUNT) ? MAX_CLASS_COUNT : cls_cnt;
    final_pos = 8'(4 + classes);
    if (elem_pos < 4) begin
      box[elem_pos[1:0]] = v;
    end else if (elem_pos == 4) begin
      obj_held  = v;
      best_prod = '0;
      top_class = '0;
    end else begin
      prod = 16'((32'(obj_held) * 32'(v)) >> 16);
      // strictly greater: a tie keeps the lower class
      if (prod > best_prod) begin
        best_prod = prod;
        top_class = 7'(elem_pos - 8'd5);
      end
    end
    if (elem_pos >= final_pos) begin
      if (obj_held >= thr && best_prod >= thr) begin
        d.pred_index  = pred_count;
        d.class_index = top_class;
        d.confidence  = best_prod;
        axis_span(box[0], box[2], img_w, d.left_x, d.right_x);
        axis_span(box[1], box[3], img_h, d.top_y, d.bottom_y);
        d.frame_done = eof;
        pending_detections = {pending_detections, d};
      end
      elem_pos   = '0;
      pred_count = eof ? '0 : pred_count + 16'd1;
    end else if (eof) begin
      // early end of frame drops the partial prediction
      elem_pos   = '0;
      pred_count = '0;
    end else begin
      elem_pos = elem_pos + 8'd1;
    end
  endtask

  task automatic check_detection(input detection_t got);
    detection_t  want;
    logic [17:0] want_f [8];
    logic [17:0] got_f [8];
    seen++;
    if (pending_detections.size() == 0) begin
      if (errors < 10) begin
        $display("detection %0d: expected none, got %h", seen, got);
      end
      errors++;
      return;
    end
    want = pending_detections.pop_front();
    want_f = '{18'(want.pred_index), 18'(want.class_index), 18'(want.confidence),
               want.left_x, want.top_y, want.right_x, want.bottom_y,
               18'(want.frame_done)};
    got_f  = '{18'(got.pred_index), 18'(got.class_index), 18'(got.confidence),
               got.left_x, got.top_y, got.right_x, got.bottom_y,
               18'(got.frame_done)};
    for (int i = 0; i < 8; i++) begin
      if (want_f[i] !== got_f[i]) begin
        if (errors < 10) begin
          $display("detection %0d %s: expected %0d, got %0d",
                   seen, field_name[i], want_f[i], got_f[i]);
        end
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_detections.delete();
      thr        = 16'd16384;
      cls_cnt    = 8'd80;
      img_w      = DIM_W'(640);
      img_h      = DIM_W'(640);
      elem_pos   = '0;
      pred_count = '0;
      for (int i = 0; i < 4; i++) box[i] = '0;
      obj_held   = '0;
      best_prod  = '0;
      top_class  = '0;
      errors     = 0;
      seen       = 0;
    end else begin
      if (m_tvalid && m_tready) check_detection({m_tlast, m_tdata[110:0]});
      if (s_tvalid && s_tready) decode_element(s_tdata, s_tlast);
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_CONF_THRESHOLD: thr     = pwdata[15:0];
          REG_CLASS_COUNT:    cls_cnt = pwdata[7:0];
          REG_IMAGE_WIDTH:    img_w   = pwdata[DIM_W-1:0];
          REG_IMAGE_HEIGHT:   img_h   = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end
    end
    pending_count  <= pending_detections.size();
    mismatch_count <= errors;
  end

endmodule

// File: verif/tb_detection_head_decode_filter.sv
// Testbench top for the detection head decode filter: clock, reset, APB setup,
// element stimulus and the verdict. Depends on dhd_pkg, dhd_tb_pkg, dhd_checker.
module tb_detection_head_decode_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import dhd_pkg::*;
  import dhd_tb_pkg::*;

  localparam int DRAIN_CYCLES   = 16;     // margin for the pipeline to empty after the last detection
  localparam int WATCHDOG_LIMIT = 2000;   // idle cycles before giving up
  localparam int RANDOM_ITEMS   = 850;
  localparam int MAX_PHASES     = 60;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic         m_tlast;
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [3:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;

  int unsigned mismatches;
  int unsigned pending;

  detection_head_decode_filter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  dhd_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatches),
    .pending_count  (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed words: {end_of_frame, value}, with class_count 2 (seven words per prediction).
  localparam logic [16:0] OPENING_WORDS [17] = '{
    // centre 0 and full size on x, full centre and zero size on y: the left corner clamps at 0
    17'h00000, 17'h0FFFF, 17'h0FFFF, 17'h00000, 17'h0FFFF, 17'h08000, 17'h0FFFF,
    // equal scores keep the lower class; end of frame on a kept detection
    17'h08000, 17'h08000, 17'h04000, 17'h04000, 17'h0C000, 17'h09000, 17'h19000,
    // end of frame after three words drops the partial prediction
    17'h01234, 17'h05678, 17'h19ABC
  };

  // Nine words of a five-class prediction, cut short later by a lower class count.
  localparam logic [16:0] LONG_WORDS [9] = '{
    17'h03000, 17'h04000, 17'h02000, 17'h01000, 17'h0FFFF,
    17'h01000, 17'h0F000, 17'h02000, 17'h08000
  };

  // Mirror of the configuration, used only to shape the stimulus.
  logic [15:0] cur_thr = 16'd16384;
  logic [7:0]  cur_cls = 8'd80;

  // Sender burst state
  bit gaps_on    = 1'b1;
  int burst_left = 0;

  // Prediction generator state for the random part
  int          gen_pos = 0;
  int          gen_len;
  int          gen_cut;
  logic        gen_eof;
  logic [15:0] gen_obj;
  int          rand_items = 0;

  // Receiver: switch between always ready, random stalls and long periodic stalls.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 2) != 0);
      default: m_tready <= ((rx_tick % 16) < 3);
    endcase
  end

  // Watchdog: count cycles in which no word moves on any channel.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Setup and access cycle of one APB write; the caller drops psel after the last one.
  task automatic write_reg(input reg_addr_e addr, input logic [31:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [15:0] thr, input logic [7:0] cls,
                           input logic [13:0] w, input logic [13:0] h);
    write_reg(REG_CONF_THRESHOLD, 32'(thr));
    write_reg(REG_CLASS_COUNT, 32'(cls));
    write_reg(REG_IMAGE_WIDTH, 32'(w));
    write_reg(REG_IMAGE_HEIGHT, 32'(h));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_thr = thr;
    cur_cls = cls;
  endtask

  // Hold one element word on the stream until it is taken; open a gap between bursts.
  task automatic send_element(input logic [15:0] v, input logic eof);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= eof;
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid, wait for every expected detection, then let the pipeline empty.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Extremes and the high corner of the range show up often.
  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(16'hC000, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [13:0] rand_dim();
    case ($urandom_range(0, 7))
      0:       return 14'd0;
      1:       return 14'd1;
      2:       return 14'd8192;
      3:       return 14'h3FFF;
      default: return 14'($urandom_range(1, 8192));
    endcase
  endfunction

  // Pin the first random settings to the extremes, then roll the rest.
  task automatic new_setting(input int phase);
    logic [15:0] thr;
    logic [7:0]  cls;
    case (phase)
      0: configure(16'h0000, 8'd0, 14'd0, 14'd8192);
      1: configure(16'hFFFF, 8'd255, 14'h3FFF, 14'd0);
      2: configure(16'h0001, 8'd128, 14'd1, 14'd1);
      default: begin
        case ($urandom_range(0, 5))
          0:       thr = 16'h0000;
          1:       thr = 16'hFFFF;
          default: thr = 16'($urandom_range(16'h2000, 16'hC000));
        endcase
        case ($urandom_range(0, 9))
          0:       cls = 8'd0;
          1:       cls = 8'd1;
          2:       cls = 8'd128;
          3:       cls = 8'($urandom_range(129, 255));
          default: cls = 8'($urandom_range(1, 12));
        endcase
        configure(thr, cls, rand_dim(), rand_dim());
      end
    endcase
  endtask

  // One word of a mostly well-formed prediction; some are cut by an early end of
  // frame and a few stray words are thrown in as noise.
  task automatic send_random_element();
    int          classes;
    logic [15:0] v;
    rand_items++;
    if ($urandom_range(0, 24) == 0) begin
      send_element(rand_value(), 1'($urandom_range(0, 1)));
      return;
    end
    if (gen_pos == 0) begin
      classes = (cur_cls == 0) ? 1 : (cur_cls > MAX_CLASS_COUNT) ? MAX_CLASS_COUNT : cur_cls;
      gen_len = 5 + classes;
      if ($urandom_range(0, 9) == 0) begin
        gen_cut = $urandom_range(0, gen_len - 2);
        gen_eof = 1'b1;
      end else begin
        gen_cut = gen_len - 1;
        gen_eof = ($urandom_range(0, 4) == 0);
      end
      gen_obj = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(cur_thr, 16'hFFFF))
                                           : rand_value();
    end
    if (gen_pos < 4) begin
      v = rand_value();
    end else if (gen_pos == 4) begin
      v = gen_obj;
    end else begin
      v = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(16'hE000, 16'hFFFF))
                                     : rand_value();
    end
    send_element(v, gen_eof && gen_pos == gen_cut);
    gen_pos = (gen_pos == gen_cut) ? 0 : gen_pos + 1;
  endtask

  initial begin
    int phase;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    drain();

    // Directed: extremes, class ties, early end of frame.
    configure(16'h4000, 8'd2, 14'd8192, 14'd1);
    foreach (OPENING_WORDS[i]) send_element(OPENING_WORDS[i][15:0], OPENING_WORDS[i][16]);

    // Lower the class count while a prediction is past its new last position:
    // the next word ends it, here together with the frame.
    drain();
    configure(16'h4000, 8'd5, 14'd640, 14'd480);
    foreach (LONG_WORDS[i]) send_element(LONG_WORDS[i][15:0], LONG_WORDS[i][16]);
    drain();
    configure(16'h4000, 8'd2, 14'd640, 14'd480);
    send_element(16'hFFFF, 1'b1);

    // Random phases, each under a fresh setting, until enough words; some phases
    // run the sender without gaps.
    phase = 0;
    while (rand_items < RANDOM_ITEMS && phase < MAX_PHASES) begin
      drain();
      new_setting(phase);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(40, 160)) send_random_element();
      phase++;
    end

    drain();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
